// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB/HSV converter package
// Shared constants, pipeline stage types and the divider step function.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int unsigned HUE_SCALE  = 43;
	localparam int unsigned HUE_GREEN  = 85;
	localparam int unsigned HUE_BLUE   = 171;
	localparam int unsigned REM_SCALE  = 6;
	localparam int unsigned DIV_BITS   = 2;

	localparam logic DIR_RGB2HSV = 1'b0;
	localparam logic DIR_HSV2RGB = 1'b1;

	typedef struct packed {
		logic        valid;
		logic        mode;
		logic [7:0]  mx;
		logic [7:0]  mn;
		logic [7:0]  base;
		logic [8:0]  diff;
		logic [2:0]  region;
		logic [7:0]  rem;
		logic [7:0]  s;
		logic [7:0]  v;
	} s1_t;

	typedef struct packed {
		logic        valid;
		logic        mode;
		logic        special;
		logic        neg;
		logic [7:0]  base;
		logic [7:0]  mx;
		logic [7:0]  d;
		logic [7:0]  sat_r;
		logic [7:0]  sat_q;
		logic [7:0]  sat_lo;
		logic [7:0]  hue_r;
		logic [7:0]  hue_q;
		logic [7:0]  hue_lo;
		logic [2:0]  region;
		logic [7:0]  s;
		logic [7:0]  v;
		logic [7:0]  p;
		logic [7:0]  sr;
		logic [7:0]  st;
	} s2_t;

	typedef struct packed {
		logic        valid;
		logic        mode;
		logic        special;
		logic        neg;
		logic [7:0]  base;
		logic [7:0]  mx;
		logic [7:0]  d;
		logic [7:0]  sat_r;
		logic [7:0]  sat_q;
		logic [7:0]  sat_lo;
		logic [7:0]  hue_r;
		logic [7:0]  hue_q;
		logic [7:0]  hue_lo;
		logic [7:0]  c0;
		logic [7:0]  c1;
		logic [7:0]  c2;
	} div_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] q;
		logic [7:0] lo;
	} divst_t;

	// Two steps of restoring division. The quotient is known to fit in
	// eight bits, so the partial remainder always stays below the divisor.
	function automatic divst_t div_step(input divst_t in, input logic [7:0] d);
		divst_t     st;
		logic [8:0] trial;
		st = in;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {st.r, st.lo[7]};
			st.lo = {st.lo[6:0], 1'b0};
			if (trial >= {1'b0, d}) begin
				st.r = 8'(trial - {1'b0, d});
				st.q = {st.q[6:0], 1'b1};
			end else begin
				st.r = trial[7:0];
				st.q = {st.q[6:0], 1'b0};
			end
		end
		return st;
	endfunction

endpackage

// ===== rtl/rgb_hsv_convert_8bit.sv =====
// ----------------------------------------------------------------------------
// 8-bit RGB <-> HSV converter
// Pipelined pixel converter; the direction register selects the conversion.
// ----------------------------------------------------------------------------
// Usage:
// A pixel transaction is taken at each rising edge with start high and busy
// low. busy is always low, so one pixel can be issued every clock cycle.
// The result appears on hue_or_red, sat_or_green and value_or_blue with done
// high for exactly one cycle, in issue order. The receiver cannot stall the
// block and none is needed. Throughput is one pixel per clock. The pipeline
// depth is set by the two divisions of the RGB to HSV direction, which run
// as a restoring divider doing two quotient bits per stage over four stages,
// plus an entry stage, an operand stage and the output register.
// cfg_we writes cfg_wdata into the direction register (0: RGB to HSV,
// 1: HSV to RGB); write it only while no pixel is in flight.
// Asynchronous reset clears the direction to RGB to HSV and empties the
// pipeline; no done strobe follows reset until new pixels are issued.
// ----------------------------------------------------------------------------
module rgb_hsv_convert_8bit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic [7:0] red_or_hue,
	input  logic [7:0] green_or_sat,
	input  logic [7:0] blue_or_value,
	output logic       done,
	output logic [7:0] hue_or_red,
	output logic [7:0] sat_or_green,
	output logic [7:0] value_or_blue
);

	logic             direction_q;
	rhc_pkg::s1_t     s1_d, stg_s1;
	rhc_pkg::s2_t     s2_d, stg_s2;
	rhc_pkg::div_t    s3_d, stg_s3;
	rhc_pkg::div_t    s4_d, stg_s4;
	rhc_pkg::div_t    s5_d, stg_s5;
	rhc_pkg::div_t    s6_d, stg_s6;
	logic             done_q, mode_q;
	logic [7:0]       out0_q, out1_q, out2_q;
	logic [7:0]       out0_d, out1_d, out2_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= rhc_pkg::DIR_RGB2HSV;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
		end
	end

	// Entry stage: channel extremes and hue sector.
	always_comb begin
		logic [7:0] mx, mn, h, hsub;
		s1_d       = '0;
		s1_d.valid = start;
		s1_d.mode  = direction_q;
		mx = (red_or_hue > green_or_sat) ? red_or_hue : green_or_sat;
		mx = (mx > blue_or_value) ? mx : blue_or_value;
		mn = (red_or_hue < green_or_sat) ? red_or_hue : green_or_sat;
		mn = (mn < blue_or_value) ? mn : blue_or_value;
		s1_d.mx = mx;
		s1_d.mn = mn;
		if (mx == red_or_hue) begin
			s1_d.base = 8'd0;
			s1_d.diff = {1'b0, green_or_sat} - {1'b0, blue_or_value};
		end else if (mx == green_or_sat) begin
			s1_d.base = 8'(rhc_pkg::HUE_GREEN);
			s1_d.diff = {1'b0, blue_or_value} - {1'b0, red_or_hue};
		end else begin
			s1_d.base = 8'(rhc_pkg::HUE_BLUE);
			s1_d.diff = {1'b0, red_or_hue} - {1'b0, green_or_sat};
		end
		h = red_or_hue;
		if (h >= 8'(5 * rhc_pkg::HUE_SCALE)) begin
			s1_d.region = 3'd5;
			hsub        = h - 8'(5 * rhc_pkg::HUE_SCALE);
		end else if (h >= 8'(4 * rhc_pkg::HUE_SCALE)) begin
			s1_d.region = 3'd4;
			hsub        = h - 8'(4 * rhc_pkg::HUE_SCALE);
		end else if (h >= 8'(3 * rhc_pkg::HUE_SCALE)) begin
			s1_d.region = 3'd3;
			hsub        = h - 8'(3 * rhc_pkg::HUE_SCALE);
		end else if (h >= 8'(2 * rhc_pkg::HUE_SCALE)) begin
			s1_d.region = 3'd2;
			hsub        = h - 8'(2 * rhc_pkg::HUE_SCALE);
		end else if (h >= 8'(rhc_pkg::HUE_SCALE)) begin
			s1_d.region = 3'd1;
			hsub        = h - 8'(rhc_pkg::HUE_SCALE);
		end else begin
			s1_d.region = 3'd0;
			hsub        = h;
		end
		s1_d.rem = 8'(hsub * 8'(rhc_pkg::REM_SCALE));
		s1_d.s   = green_or_sat;
		s1_d.v   = blue_or_value;
	end

	// Operand stage: dividends, divisor and the first HSV products.
	always_comb begin
		logic [7:0]  delta, mag;
		logic [15:0] snum, hnum, prod_r, prod_t, prod_p;
		delta = stg_s1.mx - stg_s1.mn;
		mag   = stg_s1.diff[8] ? 8'(-stg_s1.diff) : stg_s1.diff[7:0];
		snum  = {delta, 8'd0} - {8'd0, delta};
		hnum  = 16'(mag) * 16'(rhc_pkg::HUE_SCALE);
		prod_r = 16'(stg_s1.s) * 16'(stg_s1.rem);
		prod_t = 16'(stg_s1.s) * 16'(8'd255 - stg_s1.rem);
		prod_p = 16'(stg_s1.v) * 16'(8'd255 - stg_s1.s);
		s2_d         = '0;
		s2_d.valid   = stg_s1.valid;
		s2_d.mode    = stg_s1.mode;
		s2_d.special = (stg_s1.mx == stg_s1.mn);
		s2_d.neg     = stg_s1.diff[8];
		s2_d.base    = stg_s1.base;
		s2_d.mx      = stg_s1.mx;
		s2_d.d       = delta;
		s2_d.sat_r   = snum[15:8];
		s2_d.sat_lo  = snum[7:0];
		s2_d.hue_r   = hnum[15:8];
		s2_d.hue_lo  = hnum[7:0];
		s2_d.region  = stg_s1.region;
		s2_d.s       = stg_s1.s;
		s2_d.v       = stg_s1.v;
		s2_d.p       = prod_p[15:8];
		s2_d.sr      = prod_r[15:8];
		s2_d.st      = prod_t[15:8];
	end

	// First division stage; the HSV to RGB result is finished here.
	always_comb begin
		logic [15:0]     prod_q, prod_t;
		logic [7:0]      q, t;
		rhc_pkg::divst_t sa, ha;
		prod_q = 16'(stg_s2.v) * 16'(8'd255 - stg_s2.sr);
		prod_t = 16'(stg_s2.v) * 16'(8'd255 - stg_s2.st);
		q = prod_q[15:8];
		t = prod_t[15:8];
		sa = rhc_pkg::div_step('{r: stg_s2.sat_r, q: stg_s2.sat_q, lo: stg_s2.sat_lo},
			stg_s2.mx);
		ha = rhc_pkg::div_step('{r: stg_s2.hue_r, q: stg_s2.hue_q, lo: stg_s2.hue_lo},
			stg_s2.d);
		s3_d         = '0;
		s3_d.valid   = stg_s2.valid;
		s3_d.mode    = stg_s2.mode;
		s3_d.special = stg_s2.special;
		s3_d.neg     = stg_s2.neg;
		s3_d.base    = stg_s2.base;
		s3_d.mx      = stg_s2.mx;
		s3_d.d       = stg_s2.d;
		s3_d.sat_r   = sa.r;
		s3_d.sat_q   = sa.q;
		s3_d.sat_lo  = sa.lo;
		s3_d.hue_r   = ha.r;
		s3_d.hue_q   = ha.q;
		s3_d.hue_lo  = ha.lo;
		if (stg_s2.s == 8'd0) begin
			s3_d.c0 = stg_s2.v;
			s3_d.c1 = stg_s2.v;
			s3_d.c2 = stg_s2.v;
		end else begin
			case (stg_s2.region)
				3'd0: begin
					s3_d.c0 = stg_s2.v; s3_d.c1 = t;         s3_d.c2 = stg_s2.p;
				end
				3'd1: begin
					s3_d.c0 = q;        s3_d.c1 = stg_s2.v;  s3_d.c2 = stg_s2.p;
				end
				3'd2: begin
					s3_d.c0 = stg_s2.p; s3_d.c1 = stg_s2.v;  s3_d.c2 = t;
				end
				3'd3: begin
					s3_d.c0 = stg_s2.p; s3_d.c1 = q;         s3_d.c2 = stg_s2.v;
				end
				3'd4: begin
					s3_d.c0 = t;        s3_d.c1 = stg_s2.p;  s3_d.c2 = stg_s2.v;
				end
				default: begin
					s3_d.c0 = stg_s2.v; s3_d.c1 = stg_s2.p;  s3_d.c2 = q;
				end
			endcase
		end
	end

	function automatic rhc_pkg::div_t div_stage(input rhc_pkg::div_t in);
		rhc_pkg::div_t   o;
		rhc_pkg::divst_t sa, ha;
		o  = in;
		sa = rhc_pkg::div_step('{r: in.sat_r, q: in.sat_q, lo: in.sat_lo}, in.mx);
		ha = rhc_pkg::div_step('{r: in.hue_r, q: in.hue_q, lo: in.hue_lo}, in.d);
		o.sat_r  = sa.r;
		o.sat_q  = sa.q;
		o.sat_lo = sa.lo;
		o.hue_r  = ha.r;
		o.hue_q  = ha.q;
		o.hue_lo = ha.lo;
		return o;
	endfunction

	assign s4_d = div_stage(stg_s3);
	assign s5_d = div_stage(stg_s4);
	assign s6_d = div_stage(stg_s5);

	// Output selection; a grey or black pixel has zero hue and saturation.
	always_comb begin
		if (stg_s6.mode == rhc_pkg::DIR_HSV2RGB) begin
			out0_d = stg_s6.c0;
			out1_d = stg_s6.c1;
			out2_d = stg_s6.c2;
		end else begin
			out2_d = stg_s6.mx;
			if (stg_s6.special) begin
				out0_d = 8'd0;
				out1_d = 8'd0;
			end else begin
				out0_d = stg_s6.neg ? stg_s6.base - stg_s6.hue_q
					: stg_s6.base + stg_s6.hue_q;
				out1_d = stg_s6.sat_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s1 <= '0;
			stg_s2 <= '0;
			stg_s3 <= '0;
			stg_s4 <= '0;
			stg_s5 <= '0;
			stg_s6 <= '0;
			done_q <= 1'b0;
		end else begin
			stg_s1 <= s1_d;
			stg_s2 <= s2_d;
			stg_s3 <= s3_d;
			stg_s4 <= s4_d;
			stg_s5 <= s5_d;
			stg_s6 <= s6_d;
			done_q <= stg_s6.valid;
		end
	end

	// The data output registers and mode_q carry no reset.
	always_ff @(posedge clk) begin
		mode_q <= stg_s6.mode;
		out0_q <= out0_d;
		out1_q <= out1_d;
		out2_q <= out2_d;
	end

	assign done          = done_q;
	assign hue_or_red    = out0_q;
	assign sat_or_green  = out1_q;
	assign value_or_blue = out2_q;

`ifndef SYNTH
	a_done_follows_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(stg_s6.valid))
		else $error("done without an item in the last pipeline stage");

	a_pipe_advances: assert property (@(posedge clk) disable iff (!arst_n)
		stg_s3.valid |=> stg_s4.valid)
		else $error("item lost between division stages");

	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && mode_q == rhc_pkg::DIR_RGB2HSV && out2_q == 8'd0)
		|-> (out0_q == 8'd0 && out1_q == 8'd0))
		else $error("black pixel with nonzero hue or saturation");
`endif

endmodule
